@@ rtl/drive_route_classifier_assert.svh @@
`ifndef DRIVE_ROUTE_CLASSIFIER_ASSERT_SVH
`define DRIVE_ROUTE_CLASSIFIER_ASSERT_SVH
// implication checked on every rising clock edge, disabled in reset
`define DRC_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define DRC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

@@ rtl/drc_pkg.sv @@
package drc_pkg;
   localparam int Window = 32;
   localparam int PosW = $clog2(Window);
   localparam int FillW = $clog2(Window + 1);

   localparam logic [1:0] ST_UNKNOWN = 2'd0;
   localparam logic [1:0] ST_CITY = 2'd1;
   localparam logic [1:0] ST_CAND = 2'd2;
   localparam logic [1:0] ST_HIGHWAY = 2'd3;

   localparam logic [3:0] RS_INSUFF = 4'd0;
   localparam logic [3:0] RS_NO_SPEED = 4'd1;
   localparam logic [3:0] RS_WARM_CITY = 4'd2;
   localparam logic [3:0] RS_WARM_UP = 4'd3;
   localparam logic [3:0] RS_CRUISE = 4'd4;
   localparam logic [3:0] RS_HOLD = 4'd5;
   localparam logic [3:0] RS_EXIT = 4'd6;
   localparam logic [3:0] RS_CITY_SUST = 4'd7;
   localparam logic [3:0] RS_CAND = 4'd8;
   localparam logic [3:0] RS_CONFIRMED = 4'd9;
   localparam logic [3:0] RS_REJECTED = 4'd10;
   localparam logic [3:0] RS_CITY_PAT = 4'd11;
   localparam logic [3:0] RS_FAST_ACCEL = 4'd12;
   localparam logic [3:0] RS_CAND_WAIT = 4'd13;

   localparam logic [1:0] CFG_INTERVAL = 2'd0;
   localparam logic [1:0] CFG_GAP = 2'd1;
   localparam logic [1:0] CFG_MINWIN = 2'd2;
   localparam logic [1:0] CFG_CONFIRM = 2'd3;

   typedef struct packed {
      logic        start;   // front checks on the latched request
      logic        scan;    // accumulate one window entry
      logic        decide;  // apply the decision
   } cmd_type;

   typedef struct packed {
      logic        early;      // request too early, repeat estimate
      logic        short_path; // result finished without a window walk
      logic        scan_last;  // last window entry in this cycle
   } sts_type;

   typedef struct packed {
      logic        taken;
      logic [1:0]  rtype;
      logic [1:0]  rstate;
      logic signed [4:0] score;
      logic [6:0]  conf;
      logic [3:0]  reason;
   } result_type;
endpackage

@@ rtl/drc_ctrl.sv @@
module drc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic              load,
   output drc_pkg::cmd_type  cmd,
   input  drc_pkg::sts_type  sts
);
   import drc_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_START  = 5'b00010,
      S_SCAN   = 5'b00100,
      S_DECIDE = 5'b01000,
      S_OUT    = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign load = req_tvalid && req_tready;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (load) state_in = S_START;
         end
         S_START: begin
            cmd.start = 1'b1;
            if (sts.early || sts.short_path) state_in = S_OUT;
            else state_in = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_last) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
endmodule

@@ rtl/drc_datapath.sv @@
module drc_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [21:0]         csr_wdata,
   input  logic                load,
   input  logic [31:0]         now_ms,
   input  logic                speed_valid,
   input  logic [7:0]          speed_kph,
   input  drc_pkg::cmd_type    cmd,
   output drc_pkg::sts_type    sts,
   output drc_pkg::result_type result
);
   import drc_pkg::*;

   logic [19:0] interval_ff;
   logic [21:0] gap_ff;
   logic [5:0]  minwin_ff;
   logic [7:0]  confirm_ff;

   logic [31:0] now_ff;
   logic        valid_ff;
   logic [7:0]  speed_ff;

   logic [7:0]  speed_ring [Window];
   logic [8:0]  delta_ring [Window];

   logic [PosW-1:0]  wpos_ff;
   logic [FillW-1:0] fill_ff;
   logic [7:0]  prev_ff;
   logic        have_prev_ff;
   logic [31:0] last_ff;
   logic [7:0]  cand_ff;
   logic [7:0]  exit_ff;
   logic [16:0] dist_ff;
   logic signed [4:0] score_ff;
   logic [1:0]  mode_ff;
   logic        taken_ff;
   logic [1:0]  est_type_ff;
   logic [1:0]  est_state_ff;
   logic signed [4:0] est_score_ff;
   logic [6:0]  est_conf_ff;
   logic [3:0]  est_reason_ff;

   logic [PosW-1:0]  idx_ff;
   logic [FillW-1:0] n_ff;
   logic [12:0] sum_ff;
   logic [13:0] abs_ff;
   logic [FillW-1:0] high_ff, stops_ff, brakes_ff, fast_ff;

   // front checks
   logic [31:0] elapsed;
   logic        early, gap_reset, base_clear;
   logic [FillW-1:0] fill_base, fill_new;
   logic [PosW-1:0]  wpos_base;
   logic        have_base;
   logic [7:0]  prev_base;
   logic signed [8:0] delta_new;
   logic        warm, warm_city;

   assign elapsed = now_ff - last_ff;
   assign early = (last_ff != 32'd0) && (elapsed < {12'd0, interval_ff});
   assign gap_reset = (last_ff != 32'd0) && (elapsed > {10'd0, gap_ff});
   assign base_clear = gap_reset;
   assign fill_base = base_clear ? '0 : fill_ff;
   assign wpos_base = base_clear ? '0 : wpos_ff;
   assign have_base = base_clear ? 1'b0 : have_prev_ff;
   assign prev_base = base_clear ? 8'd0 : prev_ff;
   assign delta_new = have_base ? ($signed({1'b0, speed_ff}) - $signed({1'b0, prev_base}))
                                : 9'sd0;
   assign fill_new = (fill_base < FillW'(Window)) ? fill_base + 1'b1 : fill_base;
   assign warm = 6'(fill_new) < minwin_ff;
   assign warm_city = warm && (speed_ff <= 8'd45);

   assign sts.early = early;
   assign sts.short_path = !valid_ff || warm;
   assign sts.scan_last = (FillW'({1'b0, idx_ff}) + FillW'(1)) >= n_ff;

   // scan element
   logic [7:0] s_rd;
   logic signed [8:0] d_rd;
   logic [7:0] a_rd;
   assign s_rd = speed_ring[idx_ff];
   assign d_rd = delta_ring[idx_ff];
   assign a_rd = d_rd[8] ? 8'(-d_rd) : d_rd[7:0];

   // decision
   logic [13:0] nn;
   logic stable, hi_un, hw_ev, city_hard, city_soft, keep;
   always_comb begin
      nn = {{(14-FillW){1'b0}}, n_ff};
      stable = (20'(fast_ff) * 20'd10 <= 20'(nn)) && (20'(abs_ff) * 20'd10 <= 20'(nn) * 20'd48);
      hi_un = (20'(sum_ff) >= 20'(nn) * 20'd62) && (20'(high_ff) * 20'd5 >= 20'(nn) * 20'd3);
      hw_ev = hi_un && (20'(stops_ff) * 20'd100 <= 20'(nn) * 20'd8)
              && (20'(brakes_ff) * 20'd100 <= 20'(nn) * 20'd12) && stable;
      hi_un = hi_un && !stable;
      city_hard = (20'(sum_ff) <= 20'(nn) * 20'd28)
                  || (20'(stops_ff) * 20'd100 >= 20'(nn) * 20'd40)
                  || (20'(brakes_ff) * 20'd100 >= 20'(nn) * 20'd28);
      city_soft = (20'(sum_ff) <= 20'(nn) * 20'd45)
                  || (20'(stops_ff) * 20'd100 >= 20'(nn) * 20'd18)
                  || ((20'(high_ff) * 20'd100 <= 20'(nn) * 20'd10)
                      && (20'(brakes_ff) * 20'd100 >= 20'(nn) * 20'd14));
      keep = (20'(sum_ff) >= 20'(nn) * 20'd8) && (20'(stops_ff) * 20'd100 <= 20'(nn) * 20'd65)
             && !city_hard;
   end

   function automatic logic signed [4:0] sat_add(logic signed [4:0] a, logic signed [3:0] d);
      logic signed [5:0] t;
      t = 6'(a) + 6'(d);
      if (t > 6'sd14) return 5'sd14;
      if (t < -6'sd14) return -5'sd14;
      return 5'(t);
   endfunction

   function automatic logic [6:0] conf_of(logic [1:0] st, logic [3:0] rs,
                                          logic signed [4:0] sc, logic [7:0] ct);
      logic signed [7:0] v;
      logic [9:0] c;
      if (st == ST_HIGHWAY && rs == RS_EXIT) return 7'd45;
      if (st == ST_HIGHWAY && rs == RS_HOLD) return 7'd55;
      if (st == ST_HIGHWAY) begin
         v = 8'sd65 + 8'(sc) * 8'sd2;
         return (v > 8'sd98) ? 7'd98 : 7'(v);
      end
      if (st == ST_CAND) begin
         c = 10'd45 + 10'(ct) * 10'd3;
         return (c > 10'd82) ? 7'd82 : 7'(c);
      end
      if (st == ST_CITY) begin
         v = 8'sd68 - 8'(sc) * 8'sd2;
         return (v > 8'sd96) ? 7'd96 : 7'(v);
      end
      return 7'd20;
   endfunction

   function automatic logic [1:0] type_of(logic [1:0] st, logic [3:0] rs);
      if (st == ST_HIGHWAY && (rs == RS_EXIT || rs == RS_HOLD)) return ST_UNKNOWN;
      if (st == ST_HIGHWAY) return 2'd2;
      if (st == ST_CITY) return 2'd1;
      return 2'd0;
   endfunction

   // ring writes
   always_ff @(posedge clock) begin
      if (cmd.start && !early && valid_ff) begin
         speed_ring[wpos_base] <= speed_ff;
         delta_ring[wpos_base] <= delta_new;
      end
   end

   // decision next state
   logic [7:0]  cand_d, exit_d;
   logic [16:0] dist_d;
   logic signed [4:0] score_d;
   logic [1:0]  mode_d, est_st_d;
   logic [3:0]  est_rs_d;
   logic [17:0] dist_sum;
   always_comb begin
      cand_d = cand_ff;
      exit_d = exit_ff;
      dist_d = dist_ff;
      score_d = score_ff;
      mode_d = mode_ff;
      est_st_d = ST_CITY;
      est_rs_d = RS_CITY_PAT;
      dist_sum = 18'(dist_ff) + 18'(speed_ff);
      if (mode_ff == ST_HIGHWAY && (hw_ev || keep)) begin
         score_d = sat_add(score_ff, hw_ev ? 4'sd2 : 4'sd0);
         exit_d = '0;
         est_st_d = ST_HIGHWAY;
         est_rs_d = hw_ev ? RS_CRUISE : RS_HOLD;
      end else if (mode_ff == ST_HIGHWAY && (city_hard || city_soft)) begin
         exit_d = (exit_ff < 8'd255) ? exit_ff + 1'b1 : exit_ff;
         score_d = sat_add(score_ff, city_hard ? -4'sd3 : -4'sd1);
         if (exit_d >= 8'd24) begin
            mode_d = ST_CITY;
            cand_d = '0;
            dist_d = '0;
            est_st_d = ST_CITY;
            est_rs_d = RS_CITY_SUST;
         end else begin
            est_st_d = ST_HIGHWAY;
            est_rs_d = RS_EXIT;
         end
      end else if (hw_ev) begin
         if (mode_ff != ST_CAND) begin
            cand_d = '0;
            dist_sum = 18'(speed_ff);
         end
         mode_d = ST_CAND;
         cand_d = (cand_d < 8'd255) ? cand_d + 1'b1 : cand_d;
         dist_d = (dist_sum > 18'd131071) ? 17'd131071 : dist_sum[16:0];
         score_d = sat_add(score_ff, 4'sd4);
         exit_d = '0;
         if (cand_d >= confirm_ff && dist_d >= 17'd720) begin
            mode_d = ST_HIGHWAY;
            est_st_d = ST_HIGHWAY;
            est_rs_d = RS_CONFIRMED;
         end else begin
            est_st_d = ST_CAND;
            est_rs_d = RS_CAND;
         end
      end else if (mode_ff == ST_CAND) begin
         est_st_d = ST_CAND;
         est_rs_d = hi_un ? RS_FAST_ACCEL : RS_CAND_WAIT;
         if (city_hard || city_soft) begin
            score_d = sat_add(score_ff, city_hard ? -4'sd4 : -4'sd2);
            cand_d = (cand_ff > 8'd0) ? cand_ff - 1'b1 : cand_ff;
            if (city_hard || cand_d == 8'd0) begin
               mode_d = ST_CITY;
               dist_d = '0;
               est_st_d = ST_CITY;
               est_rs_d = city_hard ? RS_REJECTED : RS_CITY_PAT;
            end
         end
      end else begin
         mode_d = ST_CITY;
         cand_d = '0;
         dist_d = '0;
         score_d = sat_add(score_ff, city_hard ? -4'sd4 : -4'sd2);
         est_rs_d = hi_un ? RS_FAST_ACCEL : RS_CITY_PAT;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         now_ff <= now_ms;
         valid_ff <= speed_valid;
         speed_ff <= speed_kph;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= 20'd10000;
         gap_ff <= 22'd60000;
         minwin_ff <= 6'd6;
         confirm_ff <= 8'd12;
         wpos_ff <= '0;
         fill_ff <= '0;
         prev_ff <= '0;
         have_prev_ff <= 1'b0;
         last_ff <= '0;
         cand_ff <= '0;
         exit_ff <= '0;
         dist_ff <= '0;
         score_ff <= -5'sd10;
         mode_ff <= ST_UNKNOWN;
         taken_ff <= 1'b0;
         est_type_ff <= 2'd0;
         est_state_ff <= ST_UNKNOWN;
         est_score_ff <= -5'sd10;
         est_conf_ff <= 7'd20;
         est_reason_ff <= RS_INSUFF;
         idx_ff <= '0;
         n_ff <= '0;
         sum_ff <= '0;
         abs_ff <= '0;
         high_ff <= '0;
         stops_ff <= '0;
         brakes_ff <= '0;
         fast_ff <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CFG_INTERVAL: interval_ff <= csr_wdata[19:0];
               CFG_GAP: gap_ff <= csr_wdata;
               CFG_MINWIN: minwin_ff <= csr_wdata[5:0];
               CFG_CONFIRM: confirm_ff <= csr_wdata[7:0];
               default: ;
            endcase
         end
         if (cmd.start) begin
            taken_ff <= !early;
            if (!early) begin
               last_ff <= now_ff;
               idx_ff <= '0;
               sum_ff <= '0;
               abs_ff <= '0;
               high_ff <= '0;
               stops_ff <= '0;
               brakes_ff <= '0;
               fast_ff <= '0;
               n_ff <= fill_new;
               if (!valid_ff || base_clear) begin
                  cand_ff <= '0;
                  exit_ff <= '0;
                  dist_ff <= '0;
               end
               if (!valid_ff || (base_clear && !warm_city)) begin
                  score_ff <= -5'sd10;
                  mode_ff <= ST_UNKNOWN;
               end
               if (!valid_ff) begin
                  wpos_ff <= '0;
                  fill_ff <= '0;
                  prev_ff <= '0;
                  have_prev_ff <= 1'b0;
                  est_type_ff <= 2'd0;
                  est_state_ff <= ST_UNKNOWN;
                  est_score_ff <= -5'sd10;
                  est_conf_ff <= 7'd20;
                  est_reason_ff <= RS_NO_SPEED;
               end else begin
                  have_prev_ff <= 1'b1;
                  prev_ff <= speed_ff;
                  wpos_ff <= wpos_base + 1'b1;
                  fill_ff <= fill_new;
                  if (warm_city) begin
                     mode_ff <= ST_CITY;
                     score_ff <= -5'sd10;
                     est_type_ff <= 2'd1;
                     est_state_ff <= ST_CITY;
                     est_score_ff <= -5'sd10;
                     est_conf_ff <= conf_of(ST_CITY, RS_WARM_CITY, -5'sd10, 8'd0);
                     est_reason_ff <= RS_WARM_CITY;
                  end else if (warm) begin
                     est_type_ff <= 2'd0;
                     est_state_ff <= ST_UNKNOWN;
                     est_score_ff <= base_clear ? -5'sd10 : score_ff;
                     est_conf_ff <= 7'd20;
                     est_reason_ff <= RS_WARM_UP;
                  end
               end
            end
         end
         if (cmd.scan) begin
            idx_ff <= idx_ff + 1'b1;
            sum_ff <= sum_ff + 13'(s_rd);
            abs_ff <= abs_ff + 14'(a_rd);
            if (s_rd >= 8'd70) high_ff <= high_ff + 1'b1;
            if (s_rd <= 8'd2) stops_ff <= stops_ff + 1'b1;
            if (d_rd <= -9'sd6) brakes_ff <= brakes_ff + 1'b1;
            if (a_rd >= 8'd8) fast_ff <= fast_ff + 1'b1;
         end
         if (cmd.decide) begin
            cand_ff <= cand_d;
            exit_ff <= exit_d;
            dist_ff <= dist_d;
            score_ff <= score_d;
            mode_ff <= mode_d;
            est_type_ff <= type_of(est_st_d, est_rs_d);
            est_state_ff <= est_st_d;
            est_score_ff <= score_d;
            est_conf_ff <= conf_of(est_st_d, est_rs_d, score_d, cand_d);
            est_reason_ff <= est_rs_d;
         end
      end
   end

   assign result.taken = taken_ff;
   assign result.rtype = est_type_ff;
   assign result.rstate = est_state_ff;
   assign result.score = est_score_ff;
   assign result.conf = est_conf_ff;
   assign result.reason = est_reason_ff;
endmodule

@@ rtl/drive_route_classifier.sv @@
// Drive route classifier.
// Request channel req_*: one speed sample per request, taken when
// req_tvalid and req_tready are both high; tdata bit 31:0 now_ms,
// bit 32 speed_valid, bits 40:33 speed_kph.
// Response channel rsp_*: exactly one response per request carrying the
// classification (sample_taken, route_type, route_state, route_score,
// confidence_pct, reason_code).
// csr_*: register writes (index 0 interval, 1 reset gap, 2 window minimum,
// 3 confirm count), taken at an edge with csr_we high and reset low; the
// user must write only while idle, which the block itself does not enforce.
// An early, missing-speed or warm-up sample goes from the front checks to
// the response; any other sample first takes a window walk over n entries,
// n the window fill (up to 32), that reads one ring entry per cycle, then
// the decision. One request is in flight at a time; the next is taken the
// cycle after the response. Reset (synchronous) clears history, score -10,
// estimate unknown, registers to defaults. A stalled response holds in its
// register and no new request is taken until it is accepted.
module drive_route_classifier (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // now_ms, speed_valid, speed_kph
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // sample_taken, route_type, route_state,
                                    // route_score, confidence_pct, reason_code
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [21:0] csr_wdata
);
   import drc_pkg::*;

   cmd_type    cmd;
   sts_type    sts;
   result_type res;
   logic       load;

   drc_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .load(load), .cmd(cmd), .sts(sts)
   );

   drc_datapath u_dp (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .load(load), .now_ms(req_tdata[31:0]), .speed_valid(req_tdata[32]),
      .speed_kph(req_tdata[40:33]), .cmd(cmd), .sts(sts), .result(res)
   );

   assign rsp_tdata = {3'd0, res.reason, res.conf, res.score, res.rstate, res.rtype, res.taken};
endmodule

@@ rtl/drc_checker.sv @@
`include "drive_route_classifier_assert.svh"
module drc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);
   `DRC_ASSERT_NEXT(a_one_inflight, req_tvalid && req_tready, !req_tready)
   `DRC_ASSERT_IMP(a_no_overlap, rsp_tvalid, !req_tready)
   `DRC_ASSERT_IMP(a_score_range, rsp_tvalid,
      $signed(rsp_tdata[9:5]) <= 5'sd14 && $signed(rsp_tdata[9:5]) >= -5'sd14)
   `DRC_ASSERT_NEXT(a_stall_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
endmodule

bind drive_route_classifier drc_checker u_drc_checker (
   .clock(clock), .reset(reset),
   .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
